// File: rtl/sss_pkg.sv
`timescale 1ns / 1ps

package sss_pkg;

  localparam int SEGMENT_BITS = 8;
  localparam int DIGIT_W      = 4;
  localparam int STORE_DEPTH  = 4;
  localparam int ENABLE_LINES = 4;
  localparam int BIT_CNT_W    = $clog2(SEGMENT_BITS);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  localparam logic [SEGMENT_BITS-1:0] BLANK_FONT = '0;
  localparam logic [ENABLE_LINES-1:0] ENABLE_ALL_OFF = '1;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [SEGMENT_BITS-1:0] pattern;
    logic [ENABLE_LINES-1:0] enable_n;
  } scan_entry_t;

  typedef struct packed {
    logic        valid;
    scan_entry_t entry;
  } push_req_t;

  function automatic logic [SEGMENT_BITS-1:0] seg_font(input digit_t d);
    logic [SEGMENT_BITS-1:0] f;
    begin
      unique case (d)
        4'd0:    f = 8'hD7;
        4'd1:    f = 8'h14;
        4'd2:    f = 8'hCD;
        4'd3:    f = 8'h5D;
        4'd4:    f = 8'h1E;
        4'd5:    f = 8'h5B;
        4'd6:    f = 8'hDB;
        4'd7:    f = 8'h15;
        4'd8:    f = 8'hDF;
        4'd9:    f = 8'h5F;
        default: f = BLANK_FONT;
      endcase
      return f;
    end
  endfunction

endpackage

// File: rtl/sss_in_if.sv
`timescale 1ns / 1ps

interface sss_in_if import sss_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  digit_t digit_ones;
  digit_t digit_tens;
  digit_t digit_hundreds;
  digit_t digit_thousands;

  modport source (output valid, req_type, digit_ones, digit_tens, digit_hundreds,
                  digit_thousands, input ready);
  modport sink (input valid, req_type, digit_ones, digit_tens, digit_hundreds,
                digit_thousands, output ready);
endinterface

// File: rtl/sss_out_if.sv
`timescale 1ns / 1ps

interface sss_out_if import sss_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    serial_bit;
  logic [ENABLE_LINES-1:0] digit_enable_n;
  logic                    strobe_last;

  modport source (output valid, serial_bit, digit_enable_n, strobe_last, input ready);
  modport sink (input valid, serial_bit, digit_enable_n, strobe_last, output ready);
endinterface

// File: rtl/sss_front.sv
`timescale 1ns / 1ps

module sss_front import sss_pkg::*; #(
  parameter int NUM_POSITIONS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  sss_in_if.sink    in_ch,
  input  logic      push_ready,
  output push_req_t push
);

  localparam int PosW = (NUM_POSITIONS > 1) ? $clog2(NUM_POSITIONS) : 1;
  localparam int IdxW = (PosW > 2) ? PosW : 2;

  digit_t           digit_store_r [STORE_DEPTH];
  logic [PosW-1:0]  pos_r;
  logic [PosW-1:0]  pos_nxt;
  logic [IdxW-1:0]  idx;
  logic [IdxW-1:0]  pos_x;
  logic             accept;
  scan_entry_t      entry;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  always_comb begin
    pos_x = IdxW'(pos_r);
    idx   = IdxW'(NUM_POSITIONS - 1) - pos_x;
    if (idx <= IdxW'(STORE_DEPTH - 1)) begin
      entry.pattern = seg_font(digit_store_r[idx[1:0]]);
    end else begin
      entry.pattern = BLANK_FONT;
    end
    if (pos_x <= IdxW'(ENABLE_LINES - 1)) begin
      entry.enable_n = ~(ENABLE_LINES'(1) << pos_x[1:0]);
    end else begin
      entry.enable_n = ENABLE_ALL_OFF;
    end
    if (pos_r == PosW'(NUM_POSITIONS - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + PosW'(1);
    end
  end

  assign push.valid = accept && (in_ch.req_type == REQ_SCAN);
  assign push.entry = entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        digit_store_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_ch.req_type == REQ_LOAD) begin
        digit_store_r[0] <= in_ch.digit_ones;
        digit_store_r[1] <= in_ch.digit_tens;
        digit_store_r[2] <= in_ch.digit_hundreds;
        digit_store_r[3] <= in_ch.digit_thousands;
      end else begin
        pos_r <= pos_nxt;
      end
    end
  end

endmodule

// File: rtl/sss_queue.sv
`timescale 1ns / 1ps

module sss_queue import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  push_req_t   push,
  output logic        push_ready,
  input  logic        pop,
  output logic        pop_valid,
  output scan_entry_t pop_entry
);

  scan_entry_t entries_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = entries_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/sss_back.sv
`timescale 1ns / 1ps

module sss_back import sss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  input  scan_entry_t pop_entry,
  output logic        pop,
  sss_out_if.source   out_ch
);

  logic [SEGMENT_BITS-1:0] pat_r;
  logic [ENABLE_LINES-1:0] en_r;
  logic [BIT_CNT_W-1:0]    cnt_r;
  logic                    busy_r;
  logic                    fire;
  logic                    last;

  assign last  = (cnt_r == BIT_CNT_W'(SEGMENT_BITS - 1));
  assign fire  = busy_r && out_ch.ready;
  assign pop   = pop_valid && (!busy_r || (fire && last));

  assign out_ch.valid          = busy_r;
  assign out_ch.serial_bit     = pat_r[0];
  assign out_ch.digit_enable_n = en_r;
  assign out_ch.strobe_last    = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      pat_r <= pop_entry.pattern;
      en_r  <= pop_entry.enable_n;
    end else if (fire) begin
      pat_r <= pat_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (fire) begin
      if (last) begin
        busy_r <= 1'b0;
        cnt_r  <= '0;
      end else begin
        cnt_r <= cnt_r + BIT_CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/seven_segment_scan_serializer_unit.sv
`timescale 1ns / 1ps
// Four-digit multiplexed seven-segment scan serializer.
// in_ch carries requests: req_type 0 loads four decimal digits, req_type 1
// is a scan tick. A load produces no result; a scan tick produces eight
// results on out_ch, one font bit each, least significant first, with the
// active-low digit enables of the position shown and strobe_last on the
// eighth. Position 1 shows the thousands digit; the position then advances
// and wraps after NUM_POSITIONS.
// A request is taken whenever the two-entry tick queue has room, so loads
// and ticks can arrive back to back. The first result of a tick is valid
// once the tick has passed through the queue into the output shifter.
// The serializer emits one bit per cycle while out_ch.ready is high, and
// takes the next queued tick as the last bit of the current one is taken.
// Reset (synchronous, rst_n low) returns the scan to position 1, clears the
// stored digits to zero and empties the queue.
// When the receiver holds out_ch.ready low, the current bit is held, up to
// two ticks wait in the queue, and then in_ch.ready drops.

module seven_segment_scan_serializer_unit import sss_pkg::*; #(
  parameter int NUM_POSITIONS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  sss_in_if.sink    in_ch,
  sss_out_if.source out_ch
);

  push_req_t   push;
  logic        push_ready;
  logic        pop;
  logic        pop_valid;
  scan_entry_t pop_entry;

  sss_front #(
    .NUM_POSITIONS (NUM_POSITIONS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push       (push)
  );

  sss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  sss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
